### design/tpg_pkg.sv
package tpg_pkg;

    localparam int TIME_BITS  = 32;
    localparam int LEVEL_BITS = 16;
    localparam int EDGE_BITS  = TIME_BITS + 2;
    localparam int PROD_BITS  = LEVEL_BITS + TIME_BITS;
    localparam int CFG_BITS   = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
    localparam int IDX_BITS   = 3;
    localparam int IN_BITS    = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((LEVEL_BITS + EDGE_BITS + 7) / 8) * 8;

    typedef enum logic [IDX_BITS-1:0] {
        REG_INITIAL,
        REG_PULSED,
        REG_DELAY,
        REG_RISE,
        REG_FALL,
        REG_WIDTH,
        REG_PERIOD
    } reg_idx_t;

    // Settings derived from the registers, held stable between items.
    typedef struct packed {
        logic [EDGE_BITS-1:0]         e1;
        logic [EDGE_BITS-1:0]         e2;
        logic [EDGE_BITS-1:0]         e3;
        logic [EDGE_BITS-1:0]         e4;
        logic [TIME_BITS-1:0]         rise;
        logic [TIME_BITS-1:0]         fall;
        logic [TIME_BITS-1:0]         period;
        logic signed [LEVEL_BITS-1:0] v1;
        logic signed [LEVEL_BITS-1:0] v2;
        logic [LEVEL_BITS-1:0]        dmag;
        logic                         dneg;
    } cfg_t;

    // Per-item info that rides along with the ramp division.
    typedef struct packed {
        logic                         ramp;
        logic                         neg;
        logic signed [LEVEL_BITS-1:0] start;
        logic [EDGE_BITS-1:0]         dist_to_edge;
    } res_t;

endpackage

### design/tpg_mod.sv
module tpg_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [tpg_pkg::TIME_BITS-1:0] in_time,
    input  logic [tpg_pkg::TIME_BITS-1:0] period,
    output logic                          out_valid,
    output logic [tpg_pkg::TIME_BITS-1:0] out_tn
);

    localparam int TB = tpg_pkg::TIME_BITS;

    // Restoring remainder, one dividend bit per stage.
    logic          v_reg   [TB];
    logic [TB-1:0] rem_reg [TB];
    logic [TB-1:0] t_reg   [TB];

    genvar k;
    generate
        for (k = 0; k < TB; k++)
        begin : g_stage
            logic          src_v;
            logic [TB-1:0] src_rem;
            logic [TB-1:0] src_t;
            logic [TB:0]   trial;
            logic [TB:0]   diff;
            logic [TB-1:0] rem_next;

            if (k == 0)
            begin : g_first
                assign src_v   = in_valid;
                assign src_rem = '0;
                assign src_t   = in_time;
            end
            else
            begin : g_rest
                assign src_v   = v_reg[k-1];
                assign src_rem = rem_reg[k-1];
                assign src_t   = t_reg[k-1];
            end

            always_comb
            begin
                trial    = {src_rem, src_t[TB-1-k]};
                diff     = trial - {1'b0, period};
                rem_next = (trial >= {1'b0, period}) ? diff[TB-1:0] : trial[TB-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[k] <= src_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= rem_next;
                    t_reg[k]   <= src_t;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[TB-1];
    assign out_tn    = rem_reg[TB-1];

endmodule

### design/tpg_seg.sv
module tpg_seg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  tpg_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [tpg_pkg::TIME_BITS-1:0] in_tn,
    output logic                          out_valid,
    output logic [tpg_pkg::PROD_BITS-1:0] out_prod,
    output logic [tpg_pkg::TIME_BITS-1:0] out_dur,
    output tpg_pkg::res_t                 out_res
);

    localparam int TB = tpg_pkg::TIME_BITS;
    localparam int EB = tpg_pkg::EDGE_BITS;

    // Stage 1: compare the folded time against every breakpoint.
    logic          v1_reg;
    logic [TB-1:0] tn1_reg;
    logic [3:0]    le_reg;
    logic [3:0]    lt_reg;
    logic [EB-1:0] tnx;

    assign tnx = {2'b00, in_tn};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tn1_reg <= in_tn;
            le_reg  <= {tnx <= cfg.e4, tnx <= cfg.e3, tnx <= cfg.e2, tnx <= cfg.e1};
            lt_reg  <= {tnx <  cfg.e4, tnx <  cfg.e3, tnx <  cfg.e2, tnx <  cfg.e1};
        end
    end

    // Stage 2: pick the segment, elapsed ticks and the distance to the next edge.
    logic          v2_reg;
    logic [TB-1:0] el_reg;
    logic [TB-1:0] dur_reg;
    tpg_pkg::res_t res2_reg;

    logic [EB-1:0] edge_sel;
    logic [EB-1:0] tn1x;
    logic [EB-1:0] dist_next;
    logic [TB-1:0] el_next;
    logic [TB-1:0] dur_next;
    tpg_pkg::res_t res_next;
    logic          in_fall;

    assign tn1x = {2'b00, tn1_reg};

    always_comb
    begin
        if (lt_reg[0])
            edge_sel = cfg.e1;
        else if (lt_reg[1])
            edge_sel = cfg.e2;
        else if (lt_reg[2])
            edge_sel = cfg.e3;
        else if (lt_reg[3])
            edge_sel = cfg.e4;
        else
            edge_sel = {2'b00, cfg.period};

        if (lt_reg == 4'b0000 && cfg.period == '0)
            dist_next = '0;
        else
            dist_next = edge_sel - tn1x;

        in_fall = !le_reg[2];
        el_next = in_fall ? tn1_reg - cfg.e3[TB-1:0] : tn1_reg - cfg.e1[TB-1:0];
        dur_next = in_fall ? cfg.fall : cfg.rise;

        res_next.dist_to_edge = dist_next;
        res_next.ramp = (!le_reg[0] && le_reg[1]) || (!le_reg[2] && le_reg[3]);
        res_next.neg  = in_fall ? !cfg.dneg : cfg.dneg;
        if (le_reg[0] || !le_reg[3])
            res_next.start = cfg.v1;
        else if (le_reg[1])
            res_next.start = cfg.v1;
        else if (le_reg[2])
            res_next.start = cfg.v2;
        else
            res_next.start = cfg.v2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            el_reg   <= el_next;
            dur_reg  <= dur_next;
            res2_reg <= res_next;
        end
    end

    // Stage 3: product of the level step magnitude and the elapsed ticks.
    logic                          v3_reg;
    logic [tpg_pkg::PROD_BITS-1:0] prod_reg;
    logic [TB-1:0]                 dur3_reg;
    tpg_pkg::res_t                 res3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= {{TB{1'b0}}, cfg.dmag} * {{tpg_pkg::LEVEL_BITS{1'b0}}, el_reg};
            dur3_reg <= dur_reg;
            res3_reg <= res2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_prod  = prod_reg;
    assign out_dur   = dur3_reg;
    assign out_res   = res3_reg;

endmodule

### design/tpg_div.sv
module tpg_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [tpg_pkg::PROD_BITS-1:0]         in_prod,
    input  logic [tpg_pkg::TIME_BITS-1:0]         in_dur,
    input  tpg_pkg::res_t                         in_res,
    output logic                                  out_valid,
    output logic signed [tpg_pkg::LEVEL_BITS-1:0] out_level,
    output logic [tpg_pkg::EDGE_BITS-1:0]         out_dist
);

    localparam int TB = tpg_pkg::TIME_BITS;
    localparam int LB = tpg_pkg::LEVEL_BITS;

    // The quotient never exceeds the step magnitude, so the upper product
    // bits start below the divisor and LEVEL_BITS stages finish the job.
    logic          v_reg   [LB];
    logic [TB-1:0] rem_reg [LB];
    logic [LB-1:0] low_reg [LB];
    logic [LB-1:0] q_reg   [LB];
    logic [TB-1:0] dur_reg [LB];
    tpg_pkg::res_t res_reg [LB];

    genvar k;
    generate
        for (k = 0; k < LB; k++)
        begin : g_stage
            logic          src_v;
            logic [TB-1:0] src_rem;
            logic [LB-1:0] src_low;
            logic [LB-1:0] src_q;
            logic [TB-1:0] src_dur;
            tpg_pkg::res_t src_res;
            logic [TB:0]   trial;
            logic [TB:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign src_v   = in_valid;
                assign src_rem = in_prod[tpg_pkg::PROD_BITS-1:LB];
                assign src_low = in_prod[LB-1:0];
                assign src_q   = '0;
                assign src_dur = in_dur;
                assign src_res = in_res;
            end
            else
            begin : g_rest
                assign src_v   = v_reg[k-1];
                assign src_rem = rem_reg[k-1];
                assign src_low = low_reg[k-1];
                assign src_q   = q_reg[k-1];
                assign src_dur = dur_reg[k-1];
                assign src_res = res_reg[k-1];
            end

            always_comb
            begin
                trial = {src_rem, src_low[LB-1-k]};
                diff  = trial - {1'b0, src_dur};
                ge    = (trial >= {1'b0, src_dur});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[k] <= src_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= ge ? diff[TB-1:0] : trial[TB-1:0];
                    low_reg[k] <= src_low;
                    q_reg[k]   <= {src_q[LB-2:0], ge};
                    dur_reg[k] <= src_dur;
                    res_reg[k] <= src_res;
                end
            end
        end
    endgenerate

    logic [LB:0]   sum;
    tpg_pkg::res_t last;

    always_comb
    begin
        last = res_reg[LB-1];
        if (!last.ramp)
            sum = {last.start[LB-1], last.start};
        else if (last.neg)
            sum = {last.start[LB-1], last.start} - {1'b0, q_reg[LB-1]};
        else
            sum = {last.start[LB-1], last.start} + {1'b0, q_reg[LB-1]};
    end

    assign out_valid = v_reg[LB-1];
    assign out_level = sum[LB-1:0];
    assign out_dist  = last.dist_to_edge;

endmodule

### design/trapezoid_pulse_generator.sv
// Channel   Direction  Contents (lowest bits first)
// s_axis    in         tdata: sample_time[31:0]
// m_axis    out        tdata: level[15:0], next_edge_distance[49:16], zero pad to 56 bits
// cfg       in         cfg_we, cfg_index, cfg_data: one register write per cycle
//
// One transaction is accepted per clock while the skid register is empty; the period fold
// and the ramp divide each work one bit per stage.
// Reset clears all valid bits and loads the register defaults; no clearing pass is needed.
// A stalled output parks one result in a skid register, and the pipeline freezes
// only while that skid register is full.
module trapezoid_pulse_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tpg_pkg::IN_BITS-1:0]   s_axis_tdata,   // sample_time
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tpg_pkg::OUT_BITS-1:0]  m_axis_tdata,   // level, next_edge_distance
    input  logic                          cfg_we,
    input  logic [tpg_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [tpg_pkg::CFG_BITS-1:0]  cfg_data
);

    localparam int TB = tpg_pkg::TIME_BITS;
    localparam int LB = tpg_pkg::LEVEL_BITS;
    localparam int EB = tpg_pkg::EDGE_BITS;

    // Configuration registers.
    logic signed [LB-1:0] initial_reg;
    logic signed [LB-1:0] pulsed_reg;
    logic [TB-1:0]        delay_reg;
    logic [TB-1:0]        rise_reg;
    logic [TB-1:0]        fall_reg;
    logic [TB-1:0]        width_reg;
    logic [TB-1:0]        period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_reg <= '0;
            pulsed_reg  <= '0;
            delay_reg   <= '0;
            rise_reg    <= {{(TB-1){1'b0}}, 1'b1};
            fall_reg    <= {{(TB-1){1'b0}}, 1'b1};
            width_reg   <= '1;
            period_reg  <= '1;
        end
        else if (cfg_we)
        begin
            case (tpg_pkg::reg_idx_t'(cfg_index))
                tpg_pkg::REG_INITIAL: initial_reg <= cfg_data[LB-1:0];
                tpg_pkg::REG_PULSED:  pulsed_reg  <= cfg_data[LB-1:0];
                tpg_pkg::REG_DELAY:   delay_reg   <= cfg_data[TB-1:0];
                tpg_pkg::REG_RISE:    rise_reg    <= cfg_data[TB-1:0];
                tpg_pkg::REG_FALL:    fall_reg    <= cfg_data[TB-1:0];
                tpg_pkg::REG_WIDTH:   width_reg   <= cfg_data[TB-1:0];
                tpg_pkg::REG_PERIOD:  period_reg  <= cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    // Breakpoints and level step are derived and registered; the user must ensure the registers
    // change only while the block is idle, which the block itself does not enforce, so that the
    // lag of the registered copy is hidden long before any transaction reaches the compare stage.
    tpg_pkg::cfg_t cfg_reg;
    tpg_pkg::cfg_t cfg_next;
    logic [LB:0]   step;

    always_comb
    begin
        step            = {pulsed_reg[LB-1], pulsed_reg} - {initial_reg[LB-1], initial_reg};
        cfg_next.e1     = {2'b00, delay_reg};
        cfg_next.e2     = cfg_next.e1 + {2'b00, rise_reg};
        cfg_next.e3     = cfg_next.e2 + {2'b00, width_reg};
        cfg_next.e4     = cfg_next.e3 + {2'b00, fall_reg};
        cfg_next.rise   = rise_reg;
        cfg_next.fall   = fall_reg;
        cfg_next.period = period_reg;
        cfg_next.v1     = initial_reg;
        cfg_next.v2     = pulsed_reg;
        cfg_next.dneg   = step[LB];
        cfg_next.dmag   = step[LB] ? LB'(-step) : step[LB-1:0];
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    // The whole pipeline moves together unless the skid register is holding.
    logic adv;
    logic skid_v_reg;

    assign adv           = !skid_v_reg;
    assign s_axis_tready = adv;

    logic          tn_valid;
    logic [TB-1:0] tn;

    tpg_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .in_time   (s_axis_tdata[TB-1:0]),
        .period    (period_reg),
        .out_valid (tn_valid),
        .out_tn    (tn)
    );

    logic                          seg_valid;
    logic [tpg_pkg::PROD_BITS-1:0] seg_prod;
    logic [TB-1:0]                 seg_dur;
    tpg_pkg::res_t                 seg_res;

    tpg_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (tn_valid),
        .in_tn     (tn),
        .out_valid (seg_valid),
        .out_prod  (seg_prod),
        .out_dur   (seg_dur),
        .out_res   (seg_res)
    );

    logic                 p_valid;
    logic signed [LB-1:0] p_level;
    logic [EB-1:0]        p_dist;

    tpg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (seg_valid),
        .in_prod   (seg_prod),
        .in_dur    (seg_dur),
        .in_res    (seg_res),
        .out_valid (p_valid),
        .out_level (p_level),
        .out_dist  (p_dist)
    );

    // Output register plus skid register.
    logic                        out_v_reg;
    logic [tpg_pkg::OUT_BITS-1:0] out_reg;
    logic [tpg_pkg::OUT_BITS-1:0] skid_reg;
    logic [tpg_pkg::OUT_BITS-1:0] p_data;
    logic                        out_free;

    assign p_data   = {{(tpg_pkg::OUT_BITS - LB - EB){1'b0}}, p_dist, p_level};
    assign out_free = !out_v_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= p_valid;
            end
        end
        else if (p_valid && adv)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_v_reg ? skid_reg : p_data;
        end
        else if (adv)
        begin
            skid_reg <= p_data;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

endmodule
